[hdl/dtdn_pkg.sv]
// ----------------------------------------------------------------------------
// dtdn_pkg - shared types and tables for the date to day number converter
// Beat structs, error codes, register indexes and calendar tables.
// ----------------------------------------------------------------------------
package dtdn_pkg;

	// Field widths
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ERR_W   = 2;
	localparam int DOY_W   = 9;
	localparam int DN_W    = 22;
	localparam int WD_W    = 3;
	localparam int WOM_W   = 3;
	localparam int IDX_W   = 2;

	// Calendar limits
	localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1900;
	localparam logic [YEAR_W-1:0] LAST_YEAR  = 14'd9999;

	// Error codes
	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_YEAR = 2'd1;
	localparam logic [ERR_W-1:0] ERR_DATE = 2'd2;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_MIN_YEAR = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_YEAR = 2'd1;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	typedef struct packed {
		logic [ERR_W-1:0] error_code;
		logic [DOY_W-1:0] day_of_year;
		logic [DN_W-1:0]  day_number;
		logic [WD_W-1:0]  weekday;
		logic [WOM_W-1:0] week_of_month;
	} daynum_t;

	typedef struct packed {
		logic [YEAR_W-1:0] min_year;
		logic [YEAR_W-1:0] max_year;
	} cfg_regs_t;

	// Longest length of each month (February as in a leap year)
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd29;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days before the first of each month in a leap year
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] ds;
		case (m)
			4'd2:    ds = 9'd31;
			4'd3:    ds = 9'd60;
			4'd4:    ds = 9'd91;
			4'd5:    ds = 9'd121;
			4'd6:    ds = 9'd152;
			4'd7:    ds = 9'd182;
			4'd8:    ds = 9'd213;
			4'd9:    ds = 9'd244;
			4'd10:   ds = 9'd274;
			4'd11:   ds = 9'd305;
			4'd12:   ds = 9'd335;
			default: ds = 9'd0;
		endcase
		return ds;
	endfunction

endpackage

[hdl/date_to_day_number_weekday.sv]
// ----------------------------------------------------------------------------
// date_to_day_number_weekday - Gregorian date to day number and weekday
// Checks a date against the configured year range and the calendar, then
// gives day of year, day number from 1900-01-01 (day 1), weekday and the
// occurrence of that weekday within the month.
//
//   channel  dir  handshake             payload
//   in       in   in_valid / in_ready   in_data  (date_t: year, month, day)
//   out      out  out_valid / out_ready out_data (daynum_t)
//   cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data (year range)
//
// Four register stages; one date enters per cycle while in_ready is high,
// and its result is registered through stages 1 to 4 before it leaves.
// Stage 1 divides the year by 100 through a reciprocal multiply, stage 3
// holds the 365-day multiply and a reciprocal multiply for the mod-7 step.
// Each stage holds while the one after it is full and stalled; bubbles
// close up, so a stalled output still lets new dates fill empty stages.
// Reset clears all stage valid bits and sets the range to 1900..9999.
// ----------------------------------------------------------------------------
module date_to_day_number_weekday import dtdn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  date_t             in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output daynum_t           out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [YEAR_W-1:0] cfg_data
);

	cfg_regs_t regs;

	dtdn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	// ------------------------------------------------------------------
	// Pipeline flow control
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4;
	logic free1, free2, free3, free4;

	assign free4    = !v_s4 || out_ready;
	assign free3    = !v_s3 || free4;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;
	assign in_ready = free1;

	// Advance valid bits stage by stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free1) v_s1 <= in_valid;
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: range check, year / 100 for year and year - 1
	// ------------------------------------------------------------------
	logic [YEAR_W-1:0] pm1_in;
	logic [24:0]       prod_y, prod_p;
	logic              yerr_in;

	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic               yerr_s1;
	logic [7:0]         q100y_s1, q100p_s1;

	assign pm1_in = in_data.year - 14'd1;
	// floor(floor(n/4) * 5243 / 2^17) equals n / 100 for every 14-bit n
	assign prod_y = 25'(in_data.year[13:2]) * 25'd5243;
	assign prod_p = 25'(pm1_in[13:2]) * 25'd5243;
	assign yerr_in = (in_data.year < regs.min_year) || (in_data.year > regs.max_year) ||
		(in_data.year < EPOCH_YEAR) || (in_data.year > LAST_YEAR);

	always_ff @(posedge clk) begin
		if (free1) begin
			year_s1  <= in_data.year;
			month_s1 <= in_data.month;
			day_s1   <= in_data.day;
			yerr_s1  <= yerr_in;
			q100y_s1 <= prod_y[24:17];
			q100p_s1 <= prod_p[24:17];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: leap year, date check, day of year, leap count, week ordinal
	// ------------------------------------------------------------------
	logic [YEAR_W-1:0] r100, pm1_s1;
	logic              is_cent, is_leap, date_bad;
	logic [DAY_W-1:0]  mlen;
	logic [DOY_W-1:0]  doy;
	logic [11:0]       lc_full;
	logic [WOM_W-1:0]  wom;
	logic [ERR_W-1:0]  err;

	logic [ERR_W-1:0] err_s2;
	logic [DOY_W-1:0] doy_s2;
	logic [10:0]      lc_s2;
	logic [12:0]      yoff_s2;
	logic [WOM_W-1:0] wom_s2;

	assign r100    = year_s1 - 14'(14'(q100y_s1) * 14'd100);
	assign is_cent = (r100 == 14'd0);
	assign is_leap = ((year_s1[1:0] == 2'd0) && !is_cent) ||
		(is_cent && (q100y_s1[1:0] == 2'd0));
	assign mlen    = month_len(month_s1);
	assign date_bad = (month_s1 == 4'd0) || (month_s1 > 4'd12) || (day_s1 == 5'd0) ||
		(day_s1 > mlen) || (!is_leap && (month_s1 == 4'd2) && (day_s1 == 5'd29));
	assign err = yerr_s1 ? ERR_YEAR : (date_bad ? ERR_DATE : ERR_NONE);
	assign doy = month_start(month_s1) + 9'(day_s1) -
		9'(!is_leap && (month_s1 > 4'd2));
	// Leap years from 1900 up to the year before: 460 of them lie up to 1899
	assign pm1_s1  = year_s1 - 14'd1;
	assign lc_full = 12'(pm1_s1[13:2]) - 12'(q100p_s1) + 12'(q100p_s1[7:2]) - 12'd460;

	// Occurrence of this weekday in the month
	always_comb begin
		case (day_s1) inside
			[5'd0:5'd7]:   wom = 3'd1;
			[5'd8:5'd14]:  wom = 3'd2;
			[5'd15:5'd21]: wom = 3'd3;
			[5'd22:5'd28]: wom = 3'd4;
			default:       wom = 3'd5;
		endcase
	end

	always_ff @(posedge clk) begin
		if (free2) begin
			err_s2  <= err;
			doy_s2  <= doy;
			lc_s2   <= lc_full[10:0];
			yoff_s2 <= 13'(year_s1 - EPOCH_YEAR);
			wom_s2  <= wom;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: day number, weekday sum and its quotient by 7
	// ------------------------------------------------------------------
	logic [DN_W-1:0] dn;
	logic [13:0]     wsum;
	logic [28:0]     prod_7;

	logic [ERR_W-1:0] err_s3;
	logic [DOY_W-1:0] doy_s3;
	logic [DN_W-1:0]  dn_s3;
	logic [13:0]      wsum_s3;
	logic [11:0]      q7_s3;
	logic [WOM_W-1:0] wom_s3;

	assign dn = 22'(yoff_s2) * 22'd365 + 22'(lc_s2) + 22'(doy_s2);
	// 365 is 1 mod 7, so the day number mod 7 equals this much smaller sum mod 7
	assign wsum   = 14'(yoff_s2) + 14'(lc_s2) + 14'(doy_s2);
	assign prod_7 = 29'(wsum) * 29'd18725;

	always_ff @(posedge clk) begin
		if (free3) begin
			err_s3  <= err_s2;
			doy_s3  <= doy_s2;
			dn_s3   <= dn;
			wsum_s3 <= wsum;
			q7_s3   <= prod_7[28:17];
			wom_s3  <= wom_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: weekday, zero the fields of a bad date
	// ------------------------------------------------------------------
	logic [13:0]    r7;
	logic [WD_W-1:0] wd;
	logic           ok;
	daynum_t        res_s4;

	assign r7 = wsum_s3 - 14'(14'(q7_s3) * 14'd7);
	assign wd = (r7[2:0] == 3'd0) ? 3'd7 : r7[2:0];
	assign ok = (err_s3 == ERR_NONE);

	always_ff @(posedge clk) begin
		if (free4) begin
			res_s4.error_code    <= err_s3;
			res_s4.day_of_year   <= ok ? doy_s3 : '0;
			res_s4.day_number    <= ok ? dn_s3 : '0;
			res_s4.weekday       <= ok ? wd : '0;
			res_s4.week_of_month <= ok ? wom_s3 : '0;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.error_code != ERR_NONE) |->
		(out_data.day_of_year == '0) && (out_data.day_number == '0) &&
		(out_data.weekday == '0) && (out_data.week_of_month == '0))
		else $error("bad date result carries nonzero fields");

	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.error_code == ERR_NONE) |->
		(out_data.day_of_year != '0) && (out_data.day_number != '0) &&
		(out_data.weekday != '0) && (out_data.week_of_month != '0))
		else $error("valid date result has a zero field");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !free3 |=> v_s3 && $stable(dn_s3) && $stable(wsum_s3))
		else $error("stage 3 changed while stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !free1 |=> v_s1 && $stable(year_s1))
		else $error("stage 1 lost or changed a stalled date");

endmodule

[hdl/dtdn_cfg.sv]
// ----------------------------------------------------------------------------
// dtdn_cfg - year range registers
// Holds the minimum and maximum accepted year, written over the config channel.
// ----------------------------------------------------------------------------
module dtdn_cfg import dtdn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [YEAR_W-1:0] cfg_data,
	output cfg_regs_t         regs
);

	cfg_regs_t regs_q;

	// Always ready for a register beat
	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	// Write the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.min_year <= EPOCH_YEAR;
			regs_q.max_year <= LAST_YEAR;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MIN_YEAR: regs_q.min_year <= cfg_data;
				REG_MAX_YEAR: regs_q.max_year <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[tb/daynum_checker.sv]
// ----------------------------------------------------------------------------
// daynum_checker - scoreboard for the date to day number converter
// Watches the config, date and result channels, keeps its own copy of the
// year range, predicts one result per accepted date and compares every
// returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module daynum_checker import dtdn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  date_t             in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  daynum_t           out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [YEAR_W-1:0] cfg_data,
	output int                fail_count,
	output int                pending_count,
	output int                checked_count
);

	daynum_t expected_daynums[$];
	int      range_min = 1900;
	int      range_max = 9999;

	initial begin
		fail_count = 0;
		pending_count = 0;
		checked_count = 0;
	end

	function automatic bit is_leap_year(input int y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Leap years in 1..n
	function automatic int leap_count(input int n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic int days_in_month(input int m, input bit lp);
		int n;
		case (m)
			1, 3, 5, 7, 8, 10, 12: n = 31;
			4, 6, 9, 11:           n = 30;
			2:                     n = lp ? 29 : 28;
			default:               n = 0;
		endcase
		return n;
	endfunction

	// Days before the first of the month in a common year
	function automatic int days_before_month(input int m);
		int n;
		case (m)
			2:       n = 31;
			3:       n = 59;
			4:       n = 90;
			5:       n = 120;
			6:       n = 151;
			7:       n = 181;
			8:       n = 212;
			9:       n = 243;
			10:      n = 273;
			11:      n = 304;
			12:      n = 334;
			default: n = 0;
		endcase
		return n;
	endfunction

	function automatic daynum_t predict_daynum(input date_t d, input int lo, input int hi);
		daynum_t r;
		int      y;
		int      m;
		int      dd;
		int      doy;
		int      dn;
		int      wd;
		bit      lp;
		r  = '0;
		y  = int'(d.year);
		m  = int'(d.month);
		dd = int'(d.day);
		lp = is_leap_year(y);
		// year range is checked before the calendar
		if (y < lo || y > hi || y < int'(EPOCH_YEAR) || y > int'(LAST_YEAR)) begin
			r.error_code = ERR_YEAR;
		end else if (m < 1 || m > 12 || dd < 1 || dd > days_in_month(m, lp)) begin
			r.error_code = ERR_DATE;
		end else begin
			r.error_code = ERR_NONE;
			doy = days_before_month(m) + dd + ((lp && m > 2) ? 1 : 0);
			dn  = 365 * (y - int'(EPOCH_YEAR)) + leap_count(y - 1)
			    - leap_count(int'(EPOCH_YEAR) - 1) + doy;
			wd  = dn % 7;
			if (wd == 0)
				wd = 7;
			r.day_of_year   = doy[DOY_W-1:0];
			r.day_number    = dn[DN_W-1:0];
			r.weekday       = wd[WD_W-1:0];
			r.week_of_month = 3'((dd - 1) / 7 + 1);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH @%0t: %s got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// Track config writes, predict on date beats, compare on result beats
	always @(posedge clk) begin
		daynum_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MIN_YEAR)
					range_min = int'(cfg_data);
				else if (cfg_index == REG_MAX_YEAR)
					range_max = int'(cfg_data);
			end
			if (in_valid && in_ready)
				expected_daynums.push_back(predict_daynum(in_data, range_min, range_max));
			if (out_valid && out_ready) begin
				if (expected_daynums.size() == 0) begin
					report_mismatch("result with nothing expected, day_number",
						32'(out_data.day_number), 0);
				end else begin
					want = expected_daynums.pop_front();
					checked_count++;
					if (out_data.error_code !== want.error_code)
						report_mismatch("error_code", 32'(out_data.error_code),
							32'(want.error_code));
					if (out_data.day_of_year !== want.day_of_year)
						report_mismatch("day_of_year", 32'(out_data.day_of_year),
							32'(want.day_of_year));
					if (out_data.day_number !== want.day_number)
						report_mismatch("day_number", 32'(out_data.day_number),
							32'(want.day_number));
					if (out_data.weekday !== want.weekday)
						report_mismatch("weekday", 32'(out_data.weekday),
							32'(want.weekday));
					if (out_data.week_of_month !== want.week_of_month)
						report_mismatch("week_of_month", 32'(out_data.week_of_month),
							32'(want.week_of_month));
				end
			end
			pending_count = expected_daynums.size();
		end
	end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top - testbench for the date to day number converter
// Drives directed and random dates under a series of year-range settings,
// with random gaps on the date side and random stalls on the result side,
// one long result stall that backs up the pipeline, and an idle-free tail.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import dtdn_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_PER_PHASE = 80;
	localparam int NUM_PHASES = 8;
	localparam int LONG_HOLD_CYCLES = 64;
	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	date_t             in_data;
	logic              out_valid;
	logic              out_ready;
	daynum_t           out_data;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [YEAR_W-1:0] cfg_data;

	int fail_count;
	int pending_count;
	int checked_count;
	int dates_sent = 0;
	int settings_used = 1;
	int cycle_count = 0;
	int cur_min = 1900;
	int cur_max = 9999;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	date_to_day_number_weekday uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	daynum_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count)
	);

	always #1 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold on request
	initial begin
		int hold_left;
		int stall_left;
		bit hold_done;
		hold_left = 0;
		stall_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one date and hold it until the beat is taken
	task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic [DAY_W-1:0] d);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{year: y, month: m, day: d};
		do @(posedge clk); while (!(in_valid && in_ready));
		dates_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[YEAR_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_year_range(input int lo, input int hi);
		drain_results();
		write_reg(REG_MIN_YEAR, lo);
		write_reg(REG_MAX_YEAR, hi);
		cur_min = lo;
		cur_max = hi;
		settings_used++;
	endtask

	// Mostly well-formed dates inside the active range, some noise
	task automatic send_random_date();
		int lo;
		int hi;
		int kind;
		int y;
		int m;
		int d;
		lo = (cur_min < 1900) ? 1900 : cur_min;
		hi = (cur_max > 9999) ? 9999 : cur_max;
		if (lo > hi) begin
			lo = 1900;
			hi = 9999;
		end
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0:       y = lo;
			1:       y = hi;
			default: y = $urandom_range(lo, hi);
		endcase
		m = $urandom_range(1, 12);
		d = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
		if (kind >= 85) begin
			m = $urandom_range(0, 15);
			d = $urandom_range(0, 31);
		end else if (kind >= 70) begin
			y = $urandom_range(0, 16383);
			m = $urandom_range(0, 15);
			d = $urandom_range(0, 31);
		end
		send_date(14'(y), 4'(m), 5'(d));
	endtask

	// Edge years around the active range: first and last day of each
	task automatic send_range_edges();
		int y;
		int k;
		for (k = 0; k < 4; k++) begin
			case (k)
				0:       y = cur_min - 1;
				1:       y = cur_min;
				2:       y = cur_max;
				default: y = cur_max + 1;
			endcase
			if (y < 0)
				y = 0;
			if (y > 16383)
				y = 16383;
			send_date(14'(y), 4'd1, 5'd1);
			send_date(14'(y), 4'd12, 5'd31);
		end
	endtask

	initial begin
		int lo_list[NUM_PHASES];
		int hi_list[NUM_PHASES];
		int p;
		int i;
		int a;
		int b;
		lo_list = '{1900, 9999, 2000, 5000, 0, 16383, 1900, 1900};
		hi_list = '{1900, 9999, 2100, 3000, 16383, 0, 9999, 9999};
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_YEAR;
		cfg_data  = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Directed dates under the reset range
		send_date(1900, 1, 1);
		send_date(1900, 12, 31);
		send_date(1900, 2, 29);
		send_date(2000, 2, 29);
		send_date(2100, 2, 29);
		send_date(2024, 2, 29);
		send_date(1904, 2, 29);
		send_date(9999, 12, 31);
		send_date(1899, 12, 31);
		send_date(10000, 1, 1);
		send_date(0, 0, 0);
		send_date(16383, 15, 31);
		send_date(1899, 13, 0);
		send_date(2023, 0, 10);
		send_date(2023, 13, 1);
		send_date(2023, 15, 1);
		send_date(2023, 4, 31);
		send_date(2023, 1, 0);
		send_date(2023, 1, 31);
		send_date(2023, 12, 29);
		send_date(2023, 3, 1);
		send_date(2024, 3, 1);
		send_date(2024, 12, 31);

		// Long result stall while dates keep coming, so the pipe backs up
		@(negedge clk);
		hold_req = 1'b1;
		for (i = 0; i < 24; i++)
			send_random_date();
		drain_results();

		// Writes to unused indexes must leave the range alone
		write_reg(REG_SPARE_A, 1234);
		write_reg(REG_SPARE_B, 4321);
		send_range_edges();

		for (p = 0; p < NUM_PHASES; p++) begin
			a = lo_list[p];
			b = hi_list[p];
			if (p == 6) begin
				a = $urandom_range(1900, 9999);
				b = $urandom_range(a, 9999);
			end
			set_year_range(a, b);
			// No idling in the last phase
			if (p == NUM_PHASES - 1)
				idle_on = 1'b0;
			send_range_edges();
			for (i = 0; i < RANDOM_PER_PHASE; i++)
				send_random_date();
		end

		drain_results();
		repeat (10) @(negedge clk);
		$display("Sent %0d dates under %0d year-range settings; %0d results checked.",
			dates_sent, settings_used, checked_count);
		$display("Run included a long result stall, idle gaps on both sides and a gap-free tail.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
